/* rtl/cka_pkg.sv */
// ----------------------------------------------------------------------------
// cka_pkg
// widths, constants and shared types of the chroma key alpha block
// ----------------------------------------------------------------------------
package cka_pkg;

    localparam int COMP_BITS     = 8;
    localparam int THR_BITS      = 16;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [COMP_BITS-1:0] COMP_MAX = {COMP_BITS{1'b1}};
    localparam logic [COMP_BITS-1:0] COMP_MID = {1'b1, {(COMP_BITS-1){1'b0}}};

    localparam logic [THR_BITS-1:0] THR_RESET = 16'd6528;

    // full range bt.601 luma weights in q16, index 0 is red
    localparam int LUMA_FRAC = 16;
    localparam logic [2:0][15:0] LUMA_K = {16'd7471, 16'd38470, 16'd19595};
    localparam int LUMA_W = COMP_BITS + LUMA_FRAC;

    // squared distance, scaled to q9.8 squared
    localparam int SQ_W    = 2 * COMP_BITS;
    localparam int D2_W    = SQ_W + 2;
    localparam int U_SHIFT = 16;
    localparam int U_W     = D2_W + U_SHIFT;
    localparam int ROOT_W  = U_W / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int T2_W    = 2 * THR_BITS;
    localparam int TS_W    = 2 * (THR_BITS + 1);
    localparam int CMP_W   = (U_W > TS_W) ? U_W : TS_W;

    // slope in q16 bounds every ramp numerator and denominator
    localparam int S16_W  = THR_BITS + 8;
    localparam int ANUM_W = S16_W;
    localparam int NUM_W  = ANUM_W + COMP_BITS;
    localparam int LH_W   = ((LUMA_W > S16_W) ? LUMA_W : S16_W) + 2;

    localparam int LANES      = 4;
    localparam int LANE_ALPHA = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_KEY_C0        = CFG_IDX_BITS'(0),
        REG_KEY_C1        = CFG_IDX_BITS'(1),
        REG_KEY_C2        = CFG_IDX_BITS'(2),
        REG_KEY_THRESHOLD = CFG_IDX_BITS'(3),
        REG_KEY_SLOPE     = CFG_IDX_BITS'(4),
        REG_USE_LUMA      = CFG_IDX_BITS'(5),
        REG_YUV_FORMAT    = CFG_IDX_BITS'(6),
        REG_HAS_ALPHA     = CFG_IDX_BITS'(7)
    } cfg_reg_t;

    typedef enum logic [1:0] {
        AK_ZERO,
        AK_ONE,
        AK_LUMA_RAMP,
        AK_CUBE_RAMP
    } alpha_kind_t;

    typedef struct packed {
        logic [2:0][COMP_BITS-1:0] c;
        logic [COMP_BITS-1:0]      al;
    } pix_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [U_W-1:0]    u;
    } root_st_t;

    typedef struct packed {
        alpha_kind_t       kind;
        logic [ANUM_W-1:0] anum;
        pix_t              pix;
    } root_side_t;

    typedef struct packed {
        logic [LANES-1:0][NUM_W-1:0]     rem;
        logic [LANES-1:0][COMP_BITS-1:0] q;
    } div_st_t;

    typedef struct packed {
        logic [ANUM_W-1:0] aden;
        logic [2:1]        lower;
        pix_t              pix;
    } div_side_t;

endpackage

/* rtl/cka_pix_in_if.sv */
// ----------------------------------------------------------------------------
// cka_pix_in_if
// pixel channel into the keyer, valid/ready
// ----------------------------------------------------------------------------
interface cka_pix_in_if
    import cka_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [COMP_BITS-1:0] pix_c0;
    logic [COMP_BITS-1:0] pix_c1;
    logic [COMP_BITS-1:0] pix_c2;
    logic [COMP_BITS-1:0] pix_alpha;

    modport source (output valid, output pix_c0, output pix_c1, output pix_c2,
                    output pix_alpha, input ready);
    modport sink   (input valid, input pix_c0, input pix_c1, input pix_c2,
                    input pix_alpha, output ready);
endinterface

/* rtl/cka_pix_out_if.sv */
// ----------------------------------------------------------------------------
// cka_pix_out_if
// keyed pixel channel out of the keyer, valid/ready
// ----------------------------------------------------------------------------
interface cka_pix_out_if
    import cka_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [COMP_BITS-1:0] out_c0;
    logic [COMP_BITS-1:0] out_c1;
    logic [COMP_BITS-1:0] out_c2;
    logic [COMP_BITS-1:0] out_alpha;

    modport source (output valid, output out_c0, output out_c1, output out_c2,
                    output out_alpha, input ready);
    modport sink   (input valid, input out_c0, input out_c1, input out_c2,
                    input out_alpha, output ready);
endinterface

/* rtl/cka_cfg_if.sv */
// ----------------------------------------------------------------------------
// cka_cfg_if
// register write channel, valid/ready with index and data
// ----------------------------------------------------------------------------
interface cka_cfg_if
    import cka_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/chroma_key_alpha.sv */
// ----------------------------------------------------------------------------
// chroma_key_alpha
// chroma keyer with soft matte, while not stalled one pixel per clock
// ----------------------------------------------------------------------------
// The keyer takes one pixel beat per clock while its skid register is empty
// and returns one keyed beat for each, in order, through 4 front stages
// (input register, squares and luma products, sums, region compare), 17
// stages of a one-bit-per-stage square root of the q9.8 colour distance, 2
// stages that form the ramp fraction and its products, 8 stages of a
// one-bit-per-stage divider (four lanes in parallel, alpha and three
// components) and the output register. A skid register behind the output
// register holds one beat while the sink stalls; the pipeline only stops
// when that skid is full, so ready never waits on the sink combinationally.
// Register writes are always taken; the derived values (key luma, luma
// window edges, squared thresholds) are registered from the configuration
// registers. Every pixel runs the full pipeline whatever the mode.
// ----------------------------------------------------------------------------
module chroma_key_alpha
    import cka_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    cka_pix_in_if.sink     pixel,
    cka_pix_out_if.source  keyed,
    cka_cfg_if.sink        cfg
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [2:0][COMP_BITS-1:0] key_c_reg;
    logic [THR_BITS-1:0]       key_threshold_reg;
    logic [THR_BITS-1:0]       key_slope_reg;
    logic                      use_luma_reg;
    logic                      yuv_format_reg;
    logic                      has_alpha_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_c_reg         <= '0;
            key_threshold_reg <= THR_RESET;
            key_slope_reg     <= '0;
            use_luma_reg      <= 1'b0;
            yuv_format_reg    <= 1'b0;
            has_alpha_reg     <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_KEY_C0:        key_c_reg[0]      <= cfg.data[COMP_BITS-1:0];
                REG_KEY_C1:        key_c_reg[1]      <= cfg.data[COMP_BITS-1:0];
                REG_KEY_C2:        key_c_reg[2]      <= cfg.data[COMP_BITS-1:0];
                REG_KEY_THRESHOLD: key_threshold_reg <= cfg.data[THR_BITS-1:0];
                REG_KEY_SLOPE:     key_slope_reg     <= cfg.data[THR_BITS-1:0];
                REG_USE_LUMA:      use_luma_reg      <= cfg.data[0];
                REG_YUV_FORMAT:    yuv_format_reg    <= cfg.data[0];
                REG_HAS_ALPHA:     has_alpha_reg     <= cfg.data[0];
                default:           ;  // unknown index, dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // values derived from the registers, recomputed every cycle
    // ------------------------------------------------------------------
    logic [S16_W-1:0]        s16;        // slope in q16
    logic [S16_W-1:0]        t16;        // threshold in q16
    logic [THR_BITS:0]       outer_w;    // threshold plus slope
    logic [LUMA_W-1:0]       key_luma_next, key_luma_reg;
    logic signed [LH_W-1:0]  luma_lo_next, luma_lo_reg;
    logic signed [LH_W-1:0]  luma_hi_next, luma_hi_reg;
    logic [T2_W-1:0]         thr_sq_next, thr_sq_reg;
    logic [TS_W-1:0]         outer_sq_next, outer_sq_reg;

    assign s16     = {key_slope_reg, 8'b0};
    assign t16     = {key_threshold_reg, 8'b0};
    assign outer_w = {1'b0, key_threshold_reg} + {1'b0, key_slope_reg};

    always_comb
    begin
        if (yuv_format_reg)
            key_luma_next = {key_c_reg[0], {LUMA_FRAC{1'b0}}};
        else
            key_luma_next = LUMA_W'(LUMA_K[0]) * LUMA_W'(key_c_reg[0])
                          + LUMA_W'(LUMA_K[1]) * LUMA_W'(key_c_reg[1])
                          + LUMA_W'(LUMA_K[2]) * LUMA_W'(key_c_reg[2]);
        luma_lo_next  = $signed(LH_W'(key_luma_reg)) - $signed(LH_W'(t16));
        luma_hi_next  = $signed(LH_W'(key_luma_reg)) + $signed(LH_W'(t16));
        thr_sq_next   = T2_W'(key_threshold_reg) * T2_W'(key_threshold_reg);
        outer_sq_next = TS_W'(outer_w) * TS_W'(outer_w);
    end

    always_ff @(posedge clk)
    begin
        key_luma_reg <= key_luma_next;
        luma_lo_reg  <= luma_lo_next;
        luma_hi_reg  <= luma_hi_next;
        thr_sq_reg   <= thr_sq_next;
        outer_sq_reg <= outer_sq_next;
    end

    // ------------------------------------------------------------------
    // pipeline advance: everything moves unless the skid holds a beat
    // ------------------------------------------------------------------
    logic adv;
    logic skid_valid_reg;

    assign adv         = !skid_valid_reg;
    assign pixel.ready = adv;

    // ------------------------------------------------------------------
    // front stages
    // ------------------------------------------------------------------
    logic                   s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    pix_t                   s1_pix_reg, s2_pix_reg, s3_pix_reg, s4_pix_reg;
    logic [2:0][SQ_W-1:0]   s2_sq_next, s2_sq_reg;
    logic [2:0][LUMA_W-1:0] s2_lt_next, s2_lt_reg;
    logic [D2_W-1:0]        s3_d2_next, s3_d2_reg;
    logic [LUMA_W-1:0]      s3_luma_next, s3_luma_reg;
    alpha_kind_t            s4_kind_next, s4_kind_reg;
    logic [ANUM_W-1:0]      s4_anum_next, s4_anum_reg;
    logic [U_W-1:0]         s4_u_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= pixel.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // per-component squared difference and weighted luma term
    always_comb
    begin
        logic signed [COMP_BITS:0]     diff;
        logic signed [2*COMP_BITS+1:0] prod;
        for (int i = 0; i < 3; i++)
        begin
            diff          = $signed({1'b0, s1_pix_reg.c[i]}) - $signed({1'b0, key_c_reg[i]});
            prod          = diff * diff;
            s2_sq_next[i] = SQ_W'(prod);
            s2_lt_next[i] = LUMA_W'(LUMA_K[i]) * LUMA_W'(s1_pix_reg.c[i]);
        end
    end

    always_comb
    begin
        s3_d2_next = D2_W'(s2_sq_reg[0]) + D2_W'(s2_sq_reg[1]) + D2_W'(s2_sq_reg[2]);
        if (yuv_format_reg)
            s3_luma_next = {s2_pix_reg.c[0], {LUMA_FRAC{1'b0}}};
        else
            s3_luma_next = s2_lt_reg[0] + s2_lt_reg[1] + s2_lt_reg[2];
    end

    // region test: key region, ramp band or outside
    always_comb
    begin
        logic [CMP_W-1:0]       u_ext;
        logic signed [LH_W-1:0] v;
        logic signed [LH_W-1:0] s16_s;
        logic signed [LH_W-1:0] gap_lo;
        logic signed [LH_W-1:0] gap_hi;
        u_ext        = CMP_W'({s3_d2_reg, {U_SHIFT{1'b0}}});
        v            = $signed(LH_W'(s3_luma_reg));
        s16_s        = $signed(LH_W'(s16));
        gap_lo       = luma_lo_reg - v;
        gap_hi       = v - luma_hi_reg;
        s4_anum_next = '0;
        s4_kind_next = AK_ONE;
        if (use_luma_reg)
        begin
            if (v < luma_lo_reg)
            begin
                if (gap_lo < s16_s)
                begin
                    s4_kind_next = AK_LUMA_RAMP;
                    s4_anum_next = ANUM_W'(gap_lo);
                end
            end
            else if (v >= luma_hi_reg)
            begin
                if (gap_hi < s16_s)
                begin
                    s4_kind_next = AK_LUMA_RAMP;
                    s4_anum_next = ANUM_W'(gap_hi);
                end
            end
            else
                s4_kind_next = AK_ZERO;
        end
        else
        begin
            if (u_ext < CMP_W'(thr_sq_reg))
                s4_kind_next = AK_ZERO;
            else if (u_ext < CMP_W'(outer_sq_reg))
                s4_kind_next = AK_CUBE_RAMP;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pix_reg  <= '{c: {pixel.pix_c2, pixel.pix_c1, pixel.pix_c0},
                             al: pixel.pix_alpha};
            s2_pix_reg  <= s1_pix_reg;
            s2_sq_reg   <= s2_sq_next;
            s2_lt_reg   <= s2_lt_next;
            s3_pix_reg  <= s2_pix_reg;
            s3_d2_reg   <= s3_d2_next;
            s3_luma_reg <= s3_luma_next;
            s4_pix_reg  <= s3_pix_reg;
            s4_kind_reg <= s4_kind_next;
            s4_anum_reg <= s4_anum_next;
            s4_u_reg    <= {s3_d2_reg, {U_SHIFT{1'b0}}};
        end
    end

    // ------------------------------------------------------------------
    // square root, one result bit per stage
    // ------------------------------------------------------------------
    function automatic root_st_t root_step(input root_st_t st);
        root_st_t         nx;
        logic [REM_W-1:0] rem2;
        logic [REM_W-1:0] trial;
        rem2 = {st.rem[REM_W-3:0], st.u[U_W-1 -: 2]};
        trial = REM_W'({st.root, 2'b01});
        nx.u = {st.u[U_W-3:0], 2'b00};
        if (rem2 >= trial)
        begin
            nx.rem  = rem2 - trial;
            nx.root = {st.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            nx.rem  = rem2;
            nx.root = {st.root[ROOT_W-2:0], 1'b0};
        end
        return nx;
    endfunction

    logic [ROOT_W-1:0] rt_valid_reg;
    root_st_t          rt_reg      [ROOT_W];
    root_side_t        rt_side_reg [ROOT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rt_valid_reg <= '0;
        else if (adv)
            rt_valid_reg <= {rt_valid_reg[ROOT_W-2:0], s4_valid_reg};
    end

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_root
        root_st_t   st_prev;
        root_side_t side_prev;
        if (g == 0)
        begin : g_first
            assign st_prev   = '{rem: '0, root: '0, u: s4_u_reg};
            assign side_prev = '{kind: s4_kind_reg, anum: s4_anum_reg, pix: s4_pix_reg};
        end
        else
        begin : g_rest
            assign st_prev   = rt_reg[g-1];
            assign side_prev = rt_side_reg[g-1];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rt_reg[g]      <= root_step(st_prev);
                rt_side_reg[g] <= side_prev;
            end
        end
    end

    // ------------------------------------------------------------------
    // ramp fraction anum / aden and the factor of each lane
    // ------------------------------------------------------------------
    logic                                 sel_valid_reg, mul_valid_reg;
    logic [ANUM_W-1:0]                    sel_anum_next, sel_anum_reg;
    logic [LANES-1:0][COMP_BITS-1:0]      sel_m_next, sel_m_reg;
    div_side_t                            sel_side_next, sel_side_reg, mul_side_reg;
    logic [LANES-1:0][NUM_W-1:0]          mul_num_next, mul_num_reg;

    always_comb
    begin
        root_side_t        rs;
        logic [ROOT_W-1:0] over;
        rs   = rt_side_reg[ROOT_W-1];
        over = rt_reg[ROOT_W-1].root - ROOT_W'(key_threshold_reg);
        sel_side_next.pix = rs.pix;
        unique case (rs.kind)
            AK_ZERO:
            begin
                sel_anum_next      = '0;
                sel_side_next.aden = ANUM_W'(1);
            end
            AK_ONE:
            begin
                sel_anum_next      = ANUM_W'(1);
                sel_side_next.aden = ANUM_W'(1);
            end
            AK_LUMA_RAMP:
            begin
                sel_anum_next      = rs.anum;
                sel_side_next.aden = ANUM_W'(s16);
            end
            AK_CUBE_RAMP:
            begin
                sel_anum_next      = ANUM_W'(over);
                sel_side_next.aden = ANUM_W'(key_slope_reg);
            end
            default:
            begin
                sel_anum_next      = ANUM_W'(1);
                sel_side_next.aden = ANUM_W'(1);
            end
        endcase
        // chroma of yuv is scaled as its distance from mid
        sel_m_next[0]          = rs.pix.c[0];
        sel_m_next[LANE_ALPHA] = COMP_MAX;
        for (int i = 1; i < 3; i++)
        begin
            sel_side_next.lower[i] = rs.pix.c[i] < COMP_MID;
            if (!yuv_format_reg)
                sel_m_next[i] = rs.pix.c[i];
            else if (rs.pix.c[i] < COMP_MID)
                sel_m_next[i] = COMP_MID - rs.pix.c[i];
            else
                sel_m_next[i] = rs.pix.c[i] - COMP_MID;
        end
    end

    always_comb
    begin
        for (int j = 0; j < LANES; j++)
            mul_num_next[j] = NUM_W'(sel_anum_reg) * NUM_W'(sel_m_reg[j]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sel_valid_reg <= rt_valid_reg[ROOT_W-1];
            mul_valid_reg <= sel_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sel_anum_reg <= sel_anum_next;
            sel_m_reg    <= sel_m_next;
            sel_side_reg <= sel_side_next;
            mul_num_reg  <= mul_num_next;
            mul_side_reg <= sel_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // restoring divider, one quotient bit per stage, msb first
    // quotient stays below 2^COMP_BITS since anum never exceeds aden
    // ------------------------------------------------------------------
    function automatic div_st_t div_step(input div_st_t st, input logic [ANUM_W-1:0] aden,
                                         input int sh);
        div_st_t          nx;
        logic [NUM_W-1:0] dsh;
        dsh = NUM_W'(aden) << sh;
        for (int j = 0; j < LANES; j++)
        begin
            if (st.rem[j] >= dsh)
            begin
                nx.rem[j] = st.rem[j] - dsh;
                nx.q[j]   = {st.q[j][COMP_BITS-2:0], 1'b1};
            end
            else
            begin
                nx.rem[j] = st.rem[j];
                nx.q[j]   = {st.q[j][COMP_BITS-2:0], 1'b0};
            end
        end
        return nx;
    endfunction

    logic [COMP_BITS-1:0] dv_valid_reg;
    div_st_t              dv_reg      [COMP_BITS];
    div_side_t            dv_side_reg [COMP_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg <= '0;
        else if (adv)
            dv_valid_reg <= {dv_valid_reg[COMP_BITS-2:0], mul_valid_reg};
    end

    for (genvar g = 0; g < COMP_BITS; g++)
    begin : g_div
        div_st_t   st_prev;
        div_side_t side_prev;
        if (g == 0)
        begin : g_first
            assign st_prev   = '{rem: mul_num_reg, q: '0};
            assign side_prev = mul_side_reg;
        end
        else
        begin : g_rest
            assign st_prev   = dv_reg[g-1];
            assign side_prev = dv_side_reg[g-1];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[g]      <= div_step(st_prev, side_prev.aden, COMP_BITS - 1 - g);
                dv_side_reg[g] <= side_prev;
            end
        end
    end

    // ------------------------------------------------------------------
    // result assembly
    // ------------------------------------------------------------------
    pix_t res;

    always_comb
    begin
        div_st_t              ds;
        div_side_t            sd;
        logic [COMP_BITS:0]   ceil_q;
        logic [COMP_BITS:0]   chroma;
        ds     = dv_reg[COMP_BITS-1];
        sd     = dv_side_reg[COMP_BITS-1];
        res    = sd.pix;
        ceil_q = '0;
        chroma = '0;
        if (key_threshold_reg == '0)
        begin
            // bypass: components untouched
            res.al = has_alpha_reg ? sd.pix.al : COMP_MAX;
        end
        else if (has_alpha_reg)
        begin
            res.al = (ds.q[LANE_ALPHA] < sd.pix.al) ? ds.q[LANE_ALPHA] : sd.pix.al;
        end
        else
        begin
            res.al   = COMP_MAX;
            res.c[0] = ds.q[0];
            for (int i = 1; i < 3; i++)
            begin
                // below mid the pull toward mid rounds the step up
                ceil_q = {1'b0, ds.q[i]} + {{COMP_BITS{1'b0}}, (ds.rem[i] != '0)};
                if (!yuv_format_reg)
                    chroma = {1'b0, ds.q[i]};
                else if (sd.lower[i])
                    chroma = {1'b0, COMP_MID} - ceil_q;
                else
                    chroma = {1'b0, COMP_MID} + {1'b0, ds.q[i]};
                res.c[i] = chroma[COMP_BITS-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // output register with skid
    // ------------------------------------------------------------------
    logic out_valid_reg;
    pix_t out_reg;
    pix_t skid_reg;
    logic last_valid;
    logic out_hold;

    assign last_valid = dv_valid_reg[COMP_BITS-1];
    assign out_hold   = out_valid_reg && !keyed.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_hold)
        begin
            if (adv && last_valid)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
            out_valid_reg <= last_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_hold)
        begin
            if (adv && last_valid)
                skid_reg <= res;
        end
        else if (skid_valid_reg)
            out_reg <= skid_reg;
        else
            out_reg <= res;
    end

    assign keyed.valid     = out_valid_reg;
    assign keyed.out_c0    = out_reg.c[0];
    assign keyed.out_c1    = out_reg.c[1];
    assign keyed.out_c2    = out_reg.c[2];
    assign keyed.out_alpha = out_reg.al;

endmodule
